FILE: hw/rtl/drc_pkg.sv
// Shared types and constants for the dirty rate delay controller.
// No dependencies; imported by every module of the block.
package drc_pkg;

    localparam int DRC_FRACTION_BITS = 8;
    localparam int DRC_COUNT_BITS    = 32;

    localparam int WORK_W    = 32;
    localparam int MICRO_W   = 20;
    localparam int IV_W      = 24;
    localparam int MS_W      = 32;
    localparam int RATE_W    = 32;
    localparam int DELAY_W   = 32;
    localparam int TARGET_W  = 32;
    localparam int TIMEOUT_W = 16;
    localparam int LIMIT_W   = 26;
    localparam int PHASE_W   = 2;
    localparam int IDX_W     = 2;
    localparam int DATA_W    = 32;

    localparam logic [MICRO_W-1:0] US_PER_S = 20'd1000000;
    localparam logic [9:0]         MS_PER_S = 10'd1000;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TARGET_RATE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_TIMEOUT_SEC   = 2'd1;
    localparam logic [IDX_W-1:0] REG_INITIAL_DELAY = 2'd2;

    // adjustment phase codes
    localparam logic [PHASE_W-1:0] PHASE_RAMP   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_STEADY = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CONST  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV_RATE,
        ST_MUL,
        ST_DIV_TGT,
        ST_DIFF,
        ST_CMP,
        ST_OUT
    } drc_state_t;

endpackage

FILE: hw/rtl/dirty_rate_delay_controller_unit.sv
// Top level of the dirty rate delay controller.
// Depends on drc_pkg, drc_div and drc_mul.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one tick: count_now, interval_us,
//   since_start_ms. Output channel (out_valid/out_stall) returns one result per
//   tick: work_done, rate_per_second, updated_delay, phase, hit_target, timed_out.
//   Configuration is written through wr_en/wr_index/wr_data while no tick is
//   in flight: index 0 target rate, 1 timeout in seconds, 2 initial delay.
// Timing:
//   One tick at a time. The rate division and the target division run on one
//   shared bit-serial divider, the delay multiply on one bit-serial multiplier.
//   With adjustment off the multiply and the target division are skipped.
//   in_stall is high from the accepting edge until the result is loaded into
//   the output register. A new tick is taken while a result still waits there.
// Reset:
//   Clears the previous count, sets the delay to one, the phase to ramp-up,
//   target rate and timeout to zero. A stalled result holds until taken.
module dirty_rate_delay_controller_unit
    import drc_pkg::*;
#(
    parameter int FRACTION_BITS = DRC_FRACTION_BITS,
    parameter int COUNT_BITS    = DRC_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_index,
    input  logic [DATA_W-1:0]     wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COUNT_BITS-1:0] count_now,
    input  logic [IV_W-1:0]       interval_us,
    input  logic [MS_W-1:0]       since_start_ms,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WORK_W-1:0]     work_done,
    output logic [RATE_W-1:0]     rate_per_second,
    output logic [DELAY_W-1:0]    updated_delay,
    output logic [PHASE_W-1:0]    phase,
    output logic                  hit_target,
    output logic                  timed_out
);

    localparam int SCALED_W = WORK_W + MICRO_W;
    localparam int NUM_W    = SCALED_W + FRACTION_BITS;
    localparam int RFX_W    = NUM_W;
    localparam int PROD_W   = RFX_W + DELAY_W;
    localparam int DIV_N_W  = PROD_W;
    localparam int DIV_D_W  = TARGET_W;
    localparam int CNT_W    = $clog2(DIV_N_W + 1);

    drc_state_t state_reg, state_next;

    // configuration and controller state
    logic [TARGET_W-1:0]   target_reg;
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [DELAY_W-1:0]    delay_reg;
    logic [COUNT_BITS-1:0] prev_reg;
    logic [PHASE_W-1:0]    phase_reg;

    // per-tick working registers
    logic [WORK_W-1:0]  work_reg;
    logic [IV_W-1:0]    iv_reg;
    logic [MS_W-1:0]    ms_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [PROD_W-1:0]  tgt_reg;
    logic [PROD_W-1:0]  diff_reg;
    logic [PROD_W:0]    sum_reg;
    logic               hit_reg;
    logic               fired_reg;

    // output register
    logic                  ovalid_reg;
    logic [WORK_W-1:0]     owork_reg;
    logic [RATE_W-1:0]     orate_reg;
    logic [DELAY_W-1:0]    odelay_reg;
    logic [PHASE_W-1:0]    ophase_reg;
    logic                  ohit_reg;
    logic                  ofired_reg;

    logic in_xfer;
    logic out_xfer;
    logic out_load;

    // divider and multiplier hookup
    logic               div_start;
    logic [CNT_W-1:0]   div_steps;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quotient;
    logic               mul_start;
    logic               mul_done;
    logic [PROD_W-1:0]  mul_product;

    // datapath terms
    logic [COUNT_BITS-1:0] count_diff;
    logic [63:0]           count_diff_ext;
    logic [WORK_W-1:0]     work_sat;
    logic [SCALED_W-1:0]   scaled;
    logic [NUM_W-1:0]      numerator;
    logic [RFX_W-1:0]      rfx_shift;
    logic [PROD_W-1:0]     cur;
    logic [PROD_W+4:0]     diff20;
    logic                  hit_now;
    logic [PROD_W:0]       nd_wide;
    logic [DELAY_W-1:0]    nd_sat;
    logic [DELAY_W-1:0]    nd_final;
    logic [LIMIT_W-1:0]    limit_ms;
    logic                  fire_now;
    logic                  adjust_on;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = ovalid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign count_diff     = count_now - prev_reg;
    assign count_diff_ext = 64'(count_diff);
    assign work_sat       = (count_diff_ext > 64'h0000_0000_FFFF_FFFF) ? '1
                                                                       : count_diff_ext[31:0];

    assign scaled    = SCALED_W'(work_reg) * SCALED_W'(US_PER_S);
    assign numerator = NUM_W'(scaled) << FRACTION_BITS;
    assign rfx_shift = div_quotient[RFX_W-1:0] >> FRACTION_BITS;

    assign adjust_on = (target_reg != '0) && (phase_reg != PHASE_CONST);

    assign cur    = PROD_W'(delay_reg) << FRACTION_BITS;
    assign diff20 = {diff_reg, 4'b0000} + {2'b00, diff_reg, 2'b00};
    // ramp-up hits the band when 20*|tgt - cur| < tgt
    assign hit_now = (phase_reg == PHASE_RAMP) && (diff20 < (PROD_W+5)'(tgt_reg));

    always_comb
    begin
        if ((phase_reg == PHASE_RAMP) && !hit_now)
            nd_wide = {1'b0, tgt_reg >> FRACTION_BITS};
        else
            nd_wide = sum_reg >> (FRACTION_BITS + 1);
    end

    assign nd_sat   = (|nd_wide[PROD_W:DELAY_W]) ? '1 : nd_wide[DELAY_W-1:0];
    assign nd_final = (nd_sat == '0) ? DELAY_W'(1) : nd_sat;

    assign limit_ms = LIMIT_W'(timeout_reg) * LIMIT_W'(MS_PER_S);
    assign fire_now = (timeout_reg != '0) && (ms_reg >= MS_W'(limit_ms));

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_steps    = CNT_W'(NUM_W);
        div_dividend = DIV_N_W'(numerator) << (DIV_N_W - NUM_W);
        div_divisor  = DIV_D_W'(iv_reg);
        mul_start    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_RATE;
            end
            ST_DIV_RATE:
            begin
                if (div_done)
                begin
                    if (adjust_on)
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_MUL:
            begin
                div_steps    = CNT_W'(PROD_W);
                div_dividend = mul_product;
                div_divisor  = target_reg;
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_TGT;
                end
            end
            ST_DIV_TGT:
            begin
                if (div_done)
                    state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // controller state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= '0;
            timeout_reg <= '0;
            delay_reg   <= DELAY_W'(1);
            prev_reg    <= '0;
            phase_reg   <= PHASE_RAMP;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_TARGET_RATE:   target_reg  <= wr_data[TARGET_W-1:0];
                    REG_TIMEOUT_SEC:   timeout_reg <= wr_data[TIMEOUT_W-1:0];
                    REG_INITIAL_DELAY: delay_reg   <= (wr_data == '0) ? DELAY_W'(1)
                                                                      : wr_data;
                    default:           ;
                endcase
            end
            if (in_xfer)
                prev_reg <= count_now;
            if (state_reg == ST_CMP)
            begin
                delay_reg <= nd_final;
                if (fire_now)
                    phase_reg <= PHASE_CONST;
                else if (hit_now)
                    phase_reg <= PHASE_STEADY;
            end
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_xfer)
                ovalid_reg <= 1'b0;
        end
    end

    // per-tick payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            work_reg  <= work_sat;
            iv_reg    <= (interval_us == '0) ? IV_W'(1) : interval_us;
            ms_reg    <= since_start_ms;
            hit_reg   <= 1'b0;
            fired_reg <= 1'b0;
        end
        if ((state_reg == ST_DIV_RATE) && div_done)
            rate_reg <= (|rfx_shift[RFX_W-1:RATE_W]) ? '1 : rfx_shift[RATE_W-1:0];
        if ((state_reg == ST_DIV_TGT) && div_done)
            tgt_reg <= div_quotient;
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= (tgt_reg < cur) ? (cur - tgt_reg) : (tgt_reg - cur);
            sum_reg  <= {1'b0, tgt_reg} + {1'b0, cur};
        end
        if (state_reg == ST_CMP)
        begin
            hit_reg   <= hit_now;
            fired_reg <= fire_now;
        end
        if (out_load)
        begin
            owork_reg  <= work_reg;
            orate_reg  <= rate_reg;
            odelay_reg <= delay_reg;
            ophase_reg <= phase_reg;
            ohit_reg   <= hit_reg;
            ofired_reg <= fired_reg;
        end
    end

    drc_div #(
        .N_W   (DIV_N_W),
        .D_W   (DIV_D_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // the multiplier latches the fresh rate quotient at its start pulse
    drc_mul #(
        .A_W (RFX_W),
        .B_W (DELAY_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (div_quotient[RFX_W-1:0]),
        .b       (delay_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    assign out_valid       = ovalid_reg;
    assign work_done       = owork_reg;
    assign rate_per_second = orate_reg;
    assign updated_delay   = odelay_reg;
    assign phase           = ophase_reg;
    assign hit_target      = ohit_reg;
    assign timed_out       = ofired_reg;

    // delay never drops to zero once a result is presented
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> (odelay_reg != '0))
        else $error("delay result is zero");

    // a timeout this tick leaves the block in the constant phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ofired_reg) |-> (ophase_reg == PHASE_CONST))
        else $error("timeout without constant phase");

    // reaching the band leaves ramp-up
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && ohit_reg) |-> (ophase_reg != PHASE_RAMP))
        else $error("target hit while still in ramp-up");

    // the shared divider and multiplier never finish together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(div_done && mul_done))
        else $error("divider and multiplier overlap");

    // constant phase is never left
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(phase_reg) == PHASE_CONST && !$past(wr_en)) |-> (phase_reg == PHASE_CONST))
        else $error("left constant phase");

endmodule

FILE: hw/rtl/drc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on drc_pkg. Dividend is given left-aligned; steps sets the bit count.
module drc_div
    import drc_pkg::*;
#(
    parameter int N_W   = 92,
    parameter int D_W   = 32,
    parameter int CNT_W = $clog2(N_W + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] steps,
    input  logic [N_W-1:0]   dividend,
    input  logic [D_W-1:0]   divisor,
    output logic             done,
    output logic [N_W-1:0]   quotient
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [N_W-1:0]   dq_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   dsr_reg;

    logic [D_W:0]     shifted;
    logic [D_W:0]     trial;
    logic             qbit;

    assign shifted = {rem_reg, dq_reg[N_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign qbit    = (shifted >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[N_W-2:0], qbit};
            rem_reg <= qbit ? trial[D_W-1:0] : shifted[D_W-1:0];
        end
    end

    assign done     = done_reg;
    // after all steps the padding zeros sit above the quotient bits
    assign quotient = dq_reg;

endmodule

FILE: hw/rtl/drc_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on drc_pkg.
module drc_mul
    import drc_pkg::*;
#(
    parameter int A_W = 60,
    parameter int B_W = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [A_W+B_W-1:0] p_reg;
    logic [A_W-1:0]     a_reg;
    logic [A_W:0]       sum;

    assign sum = {1'b0, p_reg[A_W+B_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= {{A_W{1'b0}}, b};
            a_reg <= a;
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule
